// ===== sv/altpi_pkg.sv =====
// Shared types and constants for the altitude PI thrust controller.
package altpi_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_POS_GAIN      = 3'd0;
   localparam logic [2:0] CSR_INTEGRAL_GAIN = 3'd1;
   localparam logic [2:0] CSR_VEL_GAIN      = 3'd2;
   localparam logic [2:0] CSR_MAX_DESCENT   = 3'd3;
   localparam logic [2:0] CSR_MAX_ASCENT    = 3'd4;
   localparam logic [2:0] CSR_VEHICLE_MASS  = 3'd5;
   localparam logic [2:0] CSR_TIME_STEP     = 3'd6;

   localparam int GAIN_W  = 31;
   localparam int TSTEP_W = 17;

   localparam logic [GAIN_W-1:0]  RST_MAX_DESCENT  = 31'd6553600;
   localparam logic [GAIN_W-1:0]  RST_MAX_ASCENT   = 31'd6553600;
   localparam logic [GAIN_W-1:0]  RST_VEHICLE_MASS = 31'd65536;
   localparam logic [TSTEP_W-1:0] RST_TIME_STEP    = 17'd131;

   // Divide by R22: |q| < 2^40, shifted up by the 16 R22 fraction bits
   localparam int R22_FRAC   = 16;
   localparam int QMAG_W     = 40;
   localparam int DIVIDEND_W = QMAG_W + R22_FRAC;
   localparam int DIVISOR_W  = 17;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_ctl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_sts_type;

endpackage

// ===== sv/altitude_pi_thrust_control_core.sv =====
// Altitude cascade controller: PI position loop, P velocity loop, thrust from mass and R22.
//
// One request is one control tick. A sequencer drives a single shared 33x33 multiplier
// through five products (error times time step, the two position gains, the velocity gain
// and the mass), with an add/saturate step after each, then a two-bit-per-cycle divider
// removes R22. A result goes to the output register after the divide; with R22 not
// positive, or with a thrust overflow caught before the divide, the divide is skipped.
// A new request is taken once the sequencer is back in idle, while the previous result
// may still wait in the output register. Arithmetic is signed fixed point with FRAC_BITS
// fraction bits; R22 is Q1.16. Products round toward minus infinity, the divide truncates
// toward zero, and the integrator saturates silently at the 32-bit limits.
module altitude_pi_thrust_control_core
   import altpi_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_target,
   input  logic signed [31:0] req_vel_target,
   input  logic signed [31:0] req_pos_measured,
   input  logic signed [31:0] req_vel_measured,
   input  logic signed [31:0] req_accel_feedforward,
   input  logic signed [17:0] req_tilt_cosine,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_thrust,
   output logic               rsp_rate_limited,
   output logic               rsp_thrust_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_M1   = 4'd1;
   localparam logic [3:0] S_A1   = 4'd2;
   localparam logic [3:0] S_M2   = 4'd3;
   localparam logic [3:0] S_A2   = 4'd4;
   localparam logic [3:0] S_M3   = 4'd5;
   localparam logic [3:0] S_A3   = 4'd6;
   localparam logic [3:0] S_C3   = 4'd7;
   localparam logic [3:0] S_V    = 4'd8;
   localparam logic [3:0] S_M4   = 4'd9;
   localparam logic [3:0] S_A4   = 4'd10;
   localparam logic [3:0] S_D    = 4'd11;
   localparam logic [3:0] S_M5   = 4'd12;
   localparam logic [3:0] S_Q    = 4'd13;
   localparam logic [3:0] S_DIV  = 4'd14;
   localparam logic [3:0] S_FIN  = 4'd15;

   localparam logic signed [63:0] GRAVITY =
      64'sd0 + ((64'sd9810 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
   localparam logic signed [63:0] MAX64  = 64'sd2147483647;
   localparam logic signed [63:0] MIN64  = -64'sd2147483648;
   localparam logic signed [63:0] QLIM   = 64'sd1 <<< QMAG_W;
   localparam logic signed [31:0] S32MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32MIN = 32'sh80000000;
   localparam logic [DIVIDEND_W-1:0] QUOT_MAXP = DIVIDEND_W'(64'd2147483647);
   localparam logic [DIVIDEND_W-1:0] QUOT_MAXN = DIVIDEND_W'(64'd2147483648);

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > MAX64)      sat32 = S32MAX;
      else if (v < MIN64) sat32 = S32MIN;
      else                sat32 = v[31:0];
   endfunction

   function automatic logic ovf32(input logic signed [63:0] v);
      ovf32 = (v > MAX64) || (v < MIN64);
   endfunction

   // configuration
   logic [GAIN_W-1:0]  pos_gain_ff, pos_gain_in;
   logic [GAIN_W-1:0]  int_gain_ff, int_gain_in;
   logic [GAIN_W-1:0]  vel_gain_ff, vel_gain_in;
   logic [GAIN_W-1:0]  max_descent_ff, max_descent_in;
   logic [GAIN_W-1:0]  max_ascent_ff, max_ascent_in;
   logic [GAIN_W-1:0]  mass_ff, mass_in;
   logic [TSTEP_W-1:0] time_step_ff, time_step_in;

   // sequencer and working registers
   logic [3:0]         state_ff, state_in;
   logic signed [31:0] pos_err_ff, pos_err_in;
   logic signed [31:0] vel_target_ff, vel_target_in;
   logic signed [31:0] vel_meas_ff, vel_meas_in;
   logic signed [31:0] accel_ff_ff, accel_ff_in;
   logic signed [17:0] tilt_ff, tilt_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] rate_ff, rate_in;
   logic signed [31:0] vel_err_ff, vel_err_in;
   logic signed [31:0] diff_ff, diff_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] thrust_ff, thrust_in;
   logic               rate_lim_ff, rate_lim_in;
   logic               sat_ff, sat_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_thrust_ff, rsp_thrust_in;
   logic               rsp_rlim_ff, rsp_rlim_in;
   logic               rsp_sat_ff, rsp_sat_in;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;

   logic signed [63:0] shifted;
   logic signed [63:0] md64, ma64, gdiff;
   logic signed [63:0] qmag;
   logic               can_load;

   div_ctl_type div_ctl;
   div_sts_type div_sts;

   altpi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_ctl (div_ctl),
      .div_sts (div_sts)
   );

   assign csr_ready = 1'b1;
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      pos_gain_in    = pos_gain_ff;
      int_gain_in    = int_gain_ff;
      vel_gain_in    = vel_gain_ff;
      max_descent_in = max_descent_ff;
      max_ascent_in  = max_ascent_ff;
      mass_in        = mass_ff;
      time_step_in   = time_step_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POS_GAIN:      pos_gain_in    = csr_data[GAIN_W-1:0];
            CSR_INTEGRAL_GAIN: int_gain_in    = csr_data[GAIN_W-1:0];
            CSR_VEL_GAIN:      vel_gain_in    = csr_data[GAIN_W-1:0];
            CSR_MAX_DESCENT:   max_descent_in = csr_data[GAIN_W-1:0];
            CSR_MAX_ASCENT:    max_ascent_in  = csr_data[GAIN_W-1:0];
            CSR_VEHICLE_MASS:  mass_in        = csr_data[GAIN_W-1:0];
            CSR_TIME_STEP:     time_step_in   = csr_data[TSTEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (state_ff)
         S_M1: begin
            mul_a = 33'(pos_err_ff);
            mul_b = $signed({16'd0, time_step_ff});
         end
         S_M2: begin
            mul_a = 33'(pos_err_ff);
            mul_b = $signed({2'd0, pos_gain_ff});
         end
         S_M3: begin
            mul_a = 33'(integ_ff);
            mul_b = $signed({2'd0, int_gain_ff});
         end
         S_M4: begin
            mul_a = 33'(vel_err_ff);
            mul_b = $signed({2'd0, vel_gain_ff});
         end
         default: begin
            mul_a = 33'(diff_ff);
            mul_b = $signed({2'd0, mass_ff});
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in      = state_ff;
      pos_err_in    = pos_err_ff;
      vel_target_in = vel_target_ff;
      vel_meas_in   = vel_meas_ff;
      accel_ff_in   = accel_ff_ff;
      tilt_in       = tilt_ff;
      integ_in      = integ_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rate_in       = rate_ff;
      vel_err_in    = vel_err_ff;
      diff_in       = diff_ff;
      neg_in        = neg_ff;
      thrust_in     = thrust_ff;
      rate_lim_in   = rate_lim_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_thrust_in = rsp_thrust_ff;
      rsp_rlim_in   = rsp_rlim_ff;
      rsp_sat_in    = rsp_sat_ff;
      can_load      = !rsp_valid_ff || !rsp_stall;

      shifted = prod_ff >>> FRAC_BITS;
      md64    = 64'($signed({1'b0, max_descent_ff}));
      ma64    = 64'($signed({1'b0, max_ascent_ff}));
      gdiff   = GRAVITY - acc_ff;
      qmag    = neg_ff ? -shifted : shifted;

      div_ctl.start    = 1'b0;
      div_ctl.dividend = {qmag[QMAG_W-1:0], {R22_FRAC{1'b0}}};
      div_ctl.divisor  = tilt_ff[DIVISOR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_err_in    = sat32(64'(req_pos_target) - 64'(req_pos_measured));
               vel_target_in = req_vel_target;
               vel_meas_in   = req_vel_measured;
               accel_ff_in   = req_accel_feedforward;
               tilt_in       = req_tilt_cosine;
               rate_lim_in   = 1'b0;
               sat_in        = 1'b0;
               state_in      = S_M1;
            end
         end
         S_M1: begin
            prod_in  = mul_p[63:0];
            state_in = S_A1;
         end
         S_A1: begin
            integ_in = sat32(64'(integ_ff) + shifted);
            state_in = S_M2;
         end
         S_M2: begin
            prod_in  = mul_p[63:0];
            state_in = S_A2;
         end
         S_A2: begin
            acc_in   = shifted + 64'(vel_target_ff);
            state_in = S_M3;
         end
         S_M3: begin
            prod_in  = mul_p[63:0];
            state_in = S_A3;
         end
         S_A3: begin
            acc_in   = acc_ff + shifted;
            state_in = S_C3;
         end
         S_C3: begin
            // descent limit wins when both would apply
            if (acc_ff < -md64) begin
               rate_in     = md64[31:0] * -32'sd1;
               rate_lim_in = 1'b1;
            end else if (acc_ff > ma64) begin
               rate_in     = ma64[31:0];
               rate_lim_in = 1'b1;
            end else begin
               rate_in = acc_ff[31:0];
            end
            state_in = S_V;
         end
         S_V: begin
            vel_err_in = sat32(64'(rate_ff) - 64'(vel_meas_ff));
            state_in   = S_M4;
         end
         S_M4: begin
            prod_in  = mul_p[63:0];
            state_in = S_A4;
         end
         S_A4: begin
            acc_in   = 64'(accel_ff_ff) + shifted;
            state_in = S_D;
         end
         S_D: begin
            diff_in = sat32(gdiff);
            if (ovf32(gdiff))
               sat_in = 1'b1;
            if (tilt_ff <= 18'sd0) begin
               // no usable tilt: thrust goes to the limit on the sign of demand
               sat_in = 1'b1;
               if (gdiff > 64'sd0)      thrust_in = S32MAX;
               else if (gdiff < 64'sd0) thrust_in = S32MIN;
               else                     thrust_in = '0;
               state_in = S_FIN;
            end else begin
               state_in = S_M5;
            end
         end
         S_M5: begin
            prod_in  = mul_p[63:0];
            neg_in   = mul_p[65];
            state_in = S_Q;
         end
         S_Q: begin
            if (shifted >= QLIM) begin
               thrust_in = S32MAX;
               sat_in    = 1'b1;
               state_in  = S_FIN;
            end else if (shifted <= -QLIM) begin
               thrust_in = S32MIN;
               sat_in    = 1'b1;
               state_in  = S_FIN;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               if (!neg_ff) begin
                  if (div_sts.quotient > QUOT_MAXP) begin
                     thrust_in = S32MAX;
                     sat_in    = 1'b1;
                  end else begin
                     thrust_in = $signed(div_sts.quotient[31:0]);
                  end
               end else begin
                  if (div_sts.quotient > QUOT_MAXN) begin
                     thrust_in = S32MIN;
                     sat_in    = 1'b1;
                  end else begin
                     thrust_in = $signed(32'd0 - div_sts.quotient[31:0]);
                  end
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_thrust_in = thrust_ff;
               rsp_rlim_in   = rate_lim_ff;
               rsp_sat_in    = sat_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_gain_ff    <= '0;
         int_gain_ff    <= '0;
         vel_gain_ff    <= '0;
         max_descent_ff <= RST_MAX_DESCENT;
         max_ascent_ff  <= RST_MAX_ASCENT;
         mass_ff        <= RST_VEHICLE_MASS;
         time_step_ff   <= RST_TIME_STEP;
         state_ff       <= S_IDLE;
         integ_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pos_gain_ff    <= pos_gain_in;
         int_gain_ff    <= int_gain_in;
         vel_gain_ff    <= vel_gain_in;
         max_descent_ff <= max_descent_in;
         max_ascent_ff  <= max_ascent_in;
         mass_ff        <= mass_in;
         time_step_ff   <= time_step_in;
         state_ff       <= state_in;
         integ_ff       <= integ_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pos_err_ff    <= pos_err_in;
      vel_target_ff <= vel_target_in;
      vel_meas_ff   <= vel_meas_in;
      accel_ff_ff   <= accel_ff_in;
      tilt_ff       <= tilt_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rate_ff       <= rate_in;
      vel_err_ff    <= vel_err_in;
      diff_ff       <= diff_in;
      neg_ff        <= neg_in;
      thrust_ff     <= thrust_in;
      rate_lim_ff   <= rate_lim_in;
      sat_ff        <= sat_in;
      rsp_thrust_ff <= rsp_thrust_in;
      rsp_rlim_ff   <= rsp_rlim_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_thrust           = rsp_thrust_ff;
   assign rsp_rate_limited     = rsp_rlim_ff;
   assign rsp_thrust_saturated = rsp_sat_ff;

   // divider only ever sees a positive R22
   a_div_pos_tilt: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> (tilt_ff > 18'sd0))
      else $error("divider started with non-positive tilt");

   // a new result only comes out of the final state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("result raised outside final state");

   // while waiting on the divide, the divider is working or has just finished
   a_div_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_sts.busy || div_sts.done))
      else $error("waiting on idle divider");

endmodule

// ===== sv/altpi_div.sv =====
// Radix-4 restoring unsigned divider, two quotient bits per cycle.
module altpi_div
   import altpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type div_ctl,
   output div_sts_type div_sts
);

   localparam int STEPS = DIVIDEND_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;

   logic [DIVISOR_W:0]    t1, t2;
   logic                  ge1, ge2;
   logic [DIVISOR_W-1:0]  r1, r2;
   logic [DIVIDEND_W-1:0] n1, n2;

   always_comb begin
      // first bit
      t1  = {rem_ff, num_ff[DIVIDEND_W-1]};
      ge1 = t1 >= {1'b0, div_ff};
      r1  = ge1 ? DIVISOR_W'(t1 - {1'b0, div_ff}) : t1[DIVISOR_W-1:0];
      n1  = {num_ff[DIVIDEND_W-2:0], ge1};
      // second bit
      t2  = {r1, n1[DIVIDEND_W-1]};
      ge2 = t2 >= {1'b0, div_ff};
      r2  = ge2 ? DIVISOR_W'(t2 - {1'b0, div_ff}) : t2[DIVISOR_W-1:0];
      n2  = {n1[DIVIDEND_W-2:0], ge2};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (div_ctl.start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(STEPS);
         num_in   = div_ctl.dividend;
         rem_in   = '0;
         div_in   = div_ctl.divisor;
      end else if (busy_ff) begin
         num_in   = n2;
         rem_in   = r2;
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign div_sts.busy     = busy_ff;
   assign div_sts.done     = done_ff;
   assign div_sts.quotient = num_ff;

endmodule

// ===== sim/altitude_pi_thrust_control_core_test.sv =====
// Self-checking bench for the altitude PI thrust controller: directed corners, random ticks.
`timescale 1ns / 1ps

module altitude_pi_thrust_control_core_test
   import altpi_pkg::*;
;

   localparam int     FRAC_BITS   = 16;
   localparam int     QUIET_LIMIT = 4000;
   localparam int     HOLD_CYCLES = 600;
   localparam int     TAIL_CYCLES = 50;
   localparam int     MAX_REPORTS = 10;
   localparam longint S32_MAX     = 64'sd2147483647;
   localparam longint S32_MIN     = -64'sd2147483648;
   localparam longint GRAVITY     = ((64'sd9810 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
   localparam longint QLIM        = 64'sd1 <<< QMAG_W;
   localparam logic [2:0]  CSR_UNUSED_INDEX = 3'd7;
   localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] W_MIN = 32'h8000_0000;
   localparam logic [17:0] LEVEL = 18'd65536;

   typedef struct {
      logic signed [31:0] pos_target;
      logic signed [31:0] vel_target;
      logic signed [31:0] pos_measured;
      logic signed [31:0] vel_measured;
      logic signed [31:0] accel_ff;
      logic signed [17:0] tilt_cosine;
   } tick_type;

   typedef struct {
      logic signed [31:0] thrust;
      logic               rate_limited;
      logic               thrust_saturated;
   } thrust_cmd_type;

   typedef struct {
      logic [GAIN_W-1:0]  pos_gain;
      logic [GAIN_W-1:0]  integral_gain;
      logic [GAIN_W-1:0]  vel_gain;
      logic [GAIN_W-1:0]  max_descent;
      logic [GAIN_W-1:0]  max_ascent;
      logic [GAIN_W-1:0]  vehicle_mass;
      logic [TSTEP_W-1:0] time_step;
   } loop_settings_type;

   typedef enum {STYLE_FLIGHT, STYLE_FULL, STYLE_ALL_MAX, STYLE_ALL_ZERO} settings_style_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_pos_target;
   logic signed [31:0] req_vel_target;
   logic signed [31:0] req_pos_measured;
   logic signed [31:0] req_vel_measured;
   logic signed [31:0] req_accel_feedforward;
   logic signed [17:0] req_tilt_cosine;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_thrust;
   logic               rsp_rate_limited;
   logic               rsp_thrust_saturated;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   // predictor state
   loop_settings_type shadow;
   longint            alt_integral;
   thrust_cmd_type    pending_cmds[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   logic hold_active  = 1'b0;
   event hold_off_go;
   int  quiet_cycles  = 0;
   int  mismatches    = 0;
   int  ticks_sent    = 0;
   int  cmds_checked  = 0;
   int  clamped_seen  = 0;
   int  saturated_seen = 0;
   int  tilted_over   = 0;
   int  csr_writes    = 0;

   altitude_pi_thrust_control_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_pos_target        (req_pos_target),
      .req_vel_target        (req_vel_target),
      .req_pos_measured      (req_pos_measured),
      .req_vel_measured      (req_vel_measured),
      .req_accel_feedforward (req_accel_feedforward),
      .req_tilt_cosine       (req_tilt_cosine),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_thrust            (rsp_thrust),
      .rsp_rate_limited      (rsp_rate_limited),
      .rsp_thrust_saturated  (rsp_thrust_saturated),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #10 clock = ~clock;

   function automatic longint clamp32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // arithmetic shift of a signed value rounds toward minus infinity
   function automatic longint floor_q(longint v);
      return v >>> FRAC_BITS;
   endfunction

   function automatic thrust_cmd_type compute_thrust(tick_type t);
      thrust_cmd_type r;
      longint pos_err, rate, vel_err, accel, raw_diff, diff, q, quo, thrust;
      r.rate_limited     = 1'b0;
      r.thrust_saturated = 1'b0;
      pos_err = clamp32(longint'(t.pos_target) - longint'(t.pos_measured));
      alt_integral = clamp32(alt_integral + floor_q(pos_err * longint'(shadow.time_step)));
      rate = floor_q(longint'(shadow.pos_gain) * pos_err)
           + floor_q(longint'(shadow.integral_gain) * alt_integral)
           + longint'(t.vel_target);
      if (rate < -longint'(shadow.max_descent)) begin
         rate = -longint'(shadow.max_descent);
         r.rate_limited = 1'b1;
      end else if (rate > longint'(shadow.max_ascent)) begin
         rate = longint'(shadow.max_ascent);
         r.rate_limited = 1'b1;
      end
      vel_err  = clamp32(rate - longint'(t.vel_measured));
      accel    = longint'(t.accel_ff) + floor_q(longint'(shadow.vel_gain) * vel_err);
      raw_diff = GRAVITY - accel;
      diff     = clamp32(raw_diff);
      if (diff != raw_diff) r.thrust_saturated = 1'b1;
      if (t.tilt_cosine <= 0) begin
         // craft upside down or on its side: thrust goes to the rail in the sign of the demand
         r.thrust_saturated = 1'b1;
         thrust = diff > 0 ? S32_MAX : (diff < 0 ? S32_MIN : 64'sd0);
      end else begin
         q = floor_q(longint'(shadow.vehicle_mass) * diff);
         if (q >= QLIM) begin
            thrust = S32_MAX;
            r.thrust_saturated = 1'b1;
         end else if (q <= -QLIM) begin
            thrust = S32_MIN;
            r.thrust_saturated = 1'b1;
         end else begin
            quo    = (q <<< R22_FRAC) / longint'(t.tilt_cosine);
            thrust = clamp32(quo);
            if (thrust != quo) r.thrust_saturated = 1'b1;
         end
      end
      r.thrust = thrust[31:0];
      return r;
   endfunction

   function automatic tick_type make_tick(logic [31:0] pt, logic [31:0] vt, logic [31:0] pm,
                                          logic [31:0] vm, logic [31:0] af, logic [17:0] tc);
      tick_type t;
      t.pos_target   = pt;
      t.vel_target   = vt;
      t.pos_measured = pm;
      t.vel_measured = vm;
      t.accel_ff     = af;
      t.tilt_cosine  = tc;
      return t;
   endfunction

   function automatic logic [31:0] near(int span);
      return 32'($urandom_range(0, 2 * span)) - 32'(span);
   endfunction

   function automatic logic [31:0] wild_word();
      case ($urandom_range(5))
         0: return W_MAX;
         1: return W_MIN;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] maybe_wild(logic [31:0] v);
      return ($urandom_range(99) < 10) ? wild_word() : v;
   endfunction

   function automatic tick_type random_tick();
      tick_type t;
      int       pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         // plausible flight: measurements close to the setpoints
         t.pos_target   = near(200 << 16);
         t.vel_target   = near(4 << 16);
         t.pos_measured = maybe_wild(t.pos_target + near(5 << 16));
         t.vel_measured = maybe_wild(t.vel_target + near(3 << 16));
         t.accel_ff     = maybe_wild(near(2 << 16));
         t.pos_target   = maybe_wild(t.pos_target);
         t.vel_target   = maybe_wild(t.vel_target);
      end else begin
         t.pos_target   = wild_word();
         t.vel_target   = wild_word();
         t.pos_measured = wild_word();
         t.vel_measured = wild_word();
         t.accel_ff     = wild_word();
      end
      pick = $urandom_range(99);
      if (pick < 75)      t.tilt_cosine = 18'($urandom_range(32768, 65536));
      else if (pick < 87) t.tilt_cosine = -18'($urandom_range(0, 131072));
      else if (pick < 93) t.tilt_cosine = 18'($urandom_range(1, 64));
      else                t.tilt_cosine = 18'($urandom);
      return t;
   endfunction

   function automatic loop_settings_type random_settings(settings_style_type style);
      loop_settings_type s;
      case (style)
         STYLE_FLIGHT: begin
            s.pos_gain      = 31'($urandom_range(0, 4 << 16));
            s.integral_gain = 31'($urandom_range(0, 1 << 16));
            s.vel_gain      = 31'($urandom_range(0, 8 << 16));
            s.max_descent   = 31'($urandom_range(0, 20 << 16));
            s.max_ascent    = 31'($urandom_range(0, 20 << 16));
            s.vehicle_mass  = 31'($urandom_range(1 << 15, 5 << 16));
            s.time_step     = 17'($urandom_range(1, 6554));
         end
         STYLE_FULL: begin
            s.pos_gain      = 31'($urandom);
            s.integral_gain = 31'($urandom);
            s.vel_gain      = 31'($urandom);
            s.max_descent   = 31'($urandom);
            s.max_ascent    = 31'($urandom);
            s.vehicle_mass  = 31'($urandom);
            s.time_step     = 17'($urandom);
         end
         STYLE_ALL_MAX: begin
            s.pos_gain      = '1;
            s.integral_gain = '1;
            s.vel_gain      = '1;
            s.max_descent   = '1;
            s.max_ascent    = '1;
            s.vehicle_mass  = '1;
            s.time_step     = '1;
         end
         default: begin
            s.pos_gain      = '0;
            s.integral_gain = '0;
            s.vel_gain      = '0;
            s.max_descent   = '0;
            s.max_ascent    = '0;
            s.vehicle_mass  = '0;
            s.time_step     = '0;
         end
      endcase
      return s;
   endfunction

   task automatic offer_tick(input tick_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_pos_target        <= t.pos_target;
      req_vel_target        <= t.vel_target;
      req_pos_measured      <= t.pos_measured;
      req_vel_measured      <= t.vel_measured;
      req_accel_feedforward <= t.accel_ff;
      req_tilt_cosine       <= t.tilt_cosine;
      do @(posedge clock); while (req_stall);
      pending_cmds.push_back(compute_thrust(t));
      ticks_sent++;
      if (t.tilt_cosine <= 0) tilted_over++;
   endtask

   // always waits on the clock before it checks the queue, so two calls never share a time step
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_cmds.size() != 0);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_POS_GAIN:      shadow.pos_gain      = data[GAIN_W-1:0];
         CSR_INTEGRAL_GAIN: shadow.integral_gain = data[GAIN_W-1:0];
         CSR_VEL_GAIN:      shadow.vel_gain      = data[GAIN_W-1:0];
         CSR_MAX_DESCENT:   shadow.max_descent   = data[GAIN_W-1:0];
         CSR_MAX_ASCENT:    shadow.max_ascent    = data[GAIN_W-1:0];
         CSR_VEHICLE_MASS:  shadow.vehicle_mass  = data[GAIN_W-1:0];
         CSR_TIME_STEP:     shadow.time_step     = data[TSTEP_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // junk in the unused upper data bits must be dropped by the block
   task automatic load_settings(input loop_settings_type s, input bit poke_unused);
      wait_drained();
      csr_write(CSR_POS_GAIN,      {1'($urandom), s.pos_gain});
      csr_write(CSR_INTEGRAL_GAIN, {1'($urandom), s.integral_gain});
      csr_write(CSR_VEL_GAIN,      {1'($urandom), s.vel_gain});
      csr_write(CSR_MAX_DESCENT,   {1'($urandom), s.max_descent});
      csr_write(CSR_MAX_ASCENT,    {1'($urandom), s.max_ascent});
      csr_write(CSR_VEHICLE_MASS,  {1'($urandom), s.vehicle_mass});
      csr_write(CSR_TIME_STEP,     {15'($urandom), s.time_step});
      if (poke_unused) csr_write(CSR_UNUSED_INDEX, '1);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      offer_tick(make_tick('0, '0, '0, '0, '0, LEVEL));
      // zero gains: rate is the setpoint alone, so it clamps; zero demand while tilted over
      offer_tick(make_tick('0, 32'h0100_0000, '0, '0, GRAVITY[31:0], '0));
      offer_tick(make_tick('0, 32'hFF00_0000, '0, '0, '0, -18'sd65536));
      wait_drained();
   endtask

   task automatic test_field_extremes();
      loop_settings_type s;
      s.pos_gain      = 31'd65536;
      s.integral_gain = 31'd16384;
      s.vel_gain      = 31'd131072;
      s.max_descent   = 31'(5 << 16);
      s.max_ascent    = 31'(3 << 16);
      s.vehicle_mass  = 31'd98304;
      s.time_step     = 17'd655;
      load_settings(s, 1'b0);
      offer_tick(make_tick(W_MAX, '0, W_MIN, '0, '0, LEVEL));
      offer_tick(make_tick(W_MIN, '0, W_MAX, '0, '0, LEVEL));
      offer_tick(make_tick('0, W_MAX, '0, '0, '0, LEVEL));
      offer_tick(make_tick('0, W_MIN, '0, '0, '0, LEVEL));
      offer_tick(make_tick('0, '0, '0, W_MAX, '0, LEVEL));
      offer_tick(make_tick('0, '0, '0, W_MIN, '0, LEVEL));
      offer_tick(make_tick('0, '0, '0, '0, W_MAX, LEVEL));
      offer_tick(make_tick('0, '0, '0, '0, W_MIN, LEVEL));
      offer_tick(make_tick('0, '0, '0, '0, '0, 18'd0));
      offer_tick(make_tick('0, '0, '0, '0, '0, '1));
      offer_tick(make_tick('0, '0, '0, '0, '0, 18'h20000));
      offer_tick(make_tick('0, '0, '0, '0, '0, 18'h1FFFF));
      offer_tick(make_tick('0, '0, '0, '0, '0, 18'd1));
      offer_tick(make_tick('1, '1, '1, '1, '1, '1));
      wait_drained();
   endtask

   task automatic test_saturation_paths();
      loop_settings_type s;
      s = random_settings(STYLE_ALL_MAX);
      s.pos_gain  = '0;
      s.vel_gain  = '0;
      s.time_step = 17'd65536;
      load_settings(s, 1'b1);
      // integrator driven into both rails
      repeat (3) offer_tick(make_tick(W_MAX, '0, W_MIN, '0, '0, LEVEL));
      repeat (3) offer_tick(make_tick(W_MIN, '0, W_MAX, '0, '0, LEVEL));
      // heavy vehicle: mass times demand overflows before the divide
      offer_tick(make_tick('0, '0, '0, '0, W_MIN, LEVEL));
      offer_tick(make_tick('0, '0, '0, '0, W_MAX, 18'd32768));
      wait_drained();
   endtask

   task automatic test_random_phases();
      settings_style_type plan [9];
      plan = '{STYLE_FLIGHT, STYLE_ALL_MAX, STYLE_FLIGHT, STYLE_FULL, STYLE_ALL_ZERO,
               STYLE_FLIGHT, STYLE_FLIGHT, STYLE_FULL, STYLE_FLIGHT};
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct <= (phase == 0) ? 34 : (phase == 1) ? 59 : 0;
         recv_idle_pct <= (phase == 0) ? 59 : (phase == 1) ? 34 : 0;
         for (int blk = 0; blk < 3; blk++) begin
            load_settings(random_settings(plan[phase * 3 + blk]), 1'b0);
            repeat (150) offer_tick(random_tick());
         end
      end
      wait_drained();
   endtask

   task automatic test_receiver_hold_off();
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      load_settings(random_settings(STYLE_FLIGHT), 1'b0);
      -> hold_off_go;
      repeat (40) offer_tick(random_tick());
      wait_drained();
   endtask

   task automatic test_drain_pause();
      send_idle_pct <= 20;
      recv_idle_pct <= 30;
      repeat (4) begin
         repeat (5) offer_tick(random_tick());
         wait_drained();
      end
   endtask

   // long receiver hold-off, counted here
   always begin
      @(hold_off_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else       rsp_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      thrust_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         cmds_checked++;
         if (pending_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected thrust command %0d with no request outstanding",
                        rsp_thrust);
         end else begin
            want = pending_cmds.pop_front();
            if (want.rate_limited) clamped_seen++;
            if (want.thrust_saturated) saturated_seen++;
            if (rsp_thrust !== want.thrust || rsp_rate_limited !== want.rate_limited ||
                rsp_thrust_saturated !== want.thrust_saturated) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("mismatch on command %0d: thrust exp %0d got %0d",
                           cmds_checked, want.thrust, rsp_thrust);
                  $display("   rate_limited exp %0b got %0b, saturated exp %0b got %0b",
                           want.rate_limited, rsp_rate_limited,
                           want.thrust_saturated, rsp_thrust_saturated);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d commands outstanding",
                  quiet_cycles, pending_cmds.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_pos_target        = '0;
      req_vel_target        = '0;
      req_pos_measured      = '0;
      req_vel_measured      = '0;
      req_accel_feedforward = '0;
      req_tilt_cosine       = '0;
      csr_valid             = 1'b0;
      csr_index             = '0;
      csr_data              = '0;
      shadow.pos_gain       = '0;
      shadow.integral_gain  = '0;
      shadow.vel_gain       = '0;
      shadow.max_descent    = RST_MAX_DESCENT;
      shadow.max_ascent     = RST_MAX_ASCENT;
      shadow.vehicle_mass   = RST_VEHICLE_MASS;
      shadow.time_step      = RST_TIME_STEP;
      alt_integral          = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_saturation_paths();
      test_random_phases();
      test_receiver_hold_off();
      test_drain_pause();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d control ticks (%0d with R22 not positive) over %0d register writes",
               ticks_sent, tilted_over, csr_writes);
      $display("checked %0d thrust commands: %0d rate-clamped, %0d saturated, %0d mismatches",
               cmds_checked, clamped_seen, saturated_seen, mismatches);
      if (mismatches == 0 && pending_cmds.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
